@@ hw/rtl/itf_pkg.sv @@
// package with shared types and constants of the integer to text formatter
package itf_pkg;
    localparam int MaxTextDefault = 64;
    localparam int QueueDepth = 2;

    typedef struct packed {
        logic [63:0] value;
        logic        is_signed;
        logic [4:0]  base;
        logic [5:0]  width;
        logic [5:0]  precision;
        logic        left_align;
        logic        zero_pad;
        logic        plus_sign;
        logic        blank_sign;
        logic        alt_prefix;
        logic        upper_case;
    } t_req;

    typedef struct packed {
        logic [7:0] text_char;
        logic       last;
    } t_chr;

    // classified job between front and back
    typedef struct packed {
        logic [63:0] mag;
        logic [4:0]  base;
        logic [5:0]  width;
        logic [5:0]  precision;
        logic        left_align;
        logic        zero_pad;
        logic [7:0]  sign_char;
        logic        has_sign;
        logic [1:0]  prefix_len;
        logic        upper_case;
    } t_job;

    function automatic logic [7:0] digit_char(input logic [3:0] d, input logic up);
        logic [7:0] c;
        if (d < 4'd10) c = 8'h30 + {4'd0, d};
        else c = (up ? 8'h41 : 8'h61) + {4'd0, d} - 8'd10;
        return c;
    endfunction
endpackage

@@ hw/rtl/itf_if.sv @@
// valid/ready channel interface carrying one item
interface itf_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

@@ hw/rtl/itf_front.sv @@
// front part: accepts items, resolves base, sign and prefix, queues jobs
module itf_front (
    input  logic i_clk,
    input  logic i_rst_n,
    itf_if.sink  s_in,
    output itf_pkg::t_job o_job,
    output logic o_job_valid,
    input  logic i_job_ready
);
    import itf_pkg::*;
    t_req       q;
    t_job       n_job;
    t_job       r_q [QueueDepth];
    logic [1:0] r_cnt;
    logic       r_wp, r_rp;
    logic       neg;
    logic       push, pop;

    assign q = s_in.data;
    assign s_in.ready = (r_cnt != 2'(QueueDepth));
    assign push = s_in.valid && s_in.ready;
    assign pop = o_job_valid && i_job_ready;
    assign o_job_valid = (r_cnt != 2'd0);
    assign o_job = r_q[r_rp];

    always_comb begin
        neg = q.is_signed && q.value[63];
        n_job.mag = neg ? (64'd0 - q.value) : q.value;
        if (q.base == 5'd0) n_job.base = 5'd10;
        else if (q.base < 5'd2) n_job.base = 5'd2;
        else if (q.base > 5'd16) n_job.base = 5'd16;
        else n_job.base = q.base;
        n_job.width = q.width;
        n_job.precision = q.precision;
        n_job.left_align = q.left_align;
        n_job.zero_pad = q.zero_pad && !q.left_align;
        n_job.upper_case = q.upper_case;
        n_job.has_sign = q.is_signed && (neg || q.plus_sign || q.blank_sign);
        n_job.sign_char = neg ? 8'h2d : (q.plus_sign ? 8'h2b : 8'h20);
        if (q.alt_prefix && n_job.base == 5'd16) n_job.prefix_len = 2'd2;
        else if (q.alt_prefix && n_job.base == 5'd8) n_job.prefix_len = 2'd1;
        else n_job.prefix_len = 2'd0;
    end

    always_ff @(posedge i_clk) begin
        if (push) r_q[r_wp] <= n_job;
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_wp <= 1'b0;
            r_rp <= 1'b0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end

    a_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 2'(QueueDepth)) else $error("queue overflow");
    a_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'(QueueDepth)) |-> !s_in.ready) else $error("ready while full");
    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd0) |-> !o_job_valid) else $error("job valid while empty");
endmodule

@@ hw/rtl/itf_back.sv @@
// back part: digit extraction by serial division, then character emission
module itf_back #(
    parameter int MAX_TEXT = itf_pkg::MaxTextDefault
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  itf_pkg::t_job i_job,
    input  logic i_job_valid,
    output logic o_job_ready,
    itf_if.source m_out
);
    import itf_pkg::*;
    localparam int TW = $clog2(MAX_TEXT + 1);

    typedef enum logic [2:0] {S_IDLE, S_DIV, S_PLAN, S_EMIT} t_state;
    typedef enum logic [2:0] {P_LSP, P_HEAD, P_ZPAD, P_PREC, P_DIG, P_TSP, P_DONE} t_phase;

    t_state      r_state;
    t_phase      r_ph;
    t_job        r_job;
    logic [63:0] r_quo;
    logic [4:0]  r_rem;
    logic [6:0]  r_bit;
    logic [3:0]  r_dg [64];
    logic [3:0]  r_dout;
    logic [6:0]  r_n;
    logic [6:0]  r_cnt;
    logic [1:0]  r_hk;
    logic [TW-1:0] r_tl;
    logic [7:0]  r_ochar;
    logic        r_olast, r_ovalid;
    logic signed [8:0] r_w;
    logic signed [8:0] r_prec;

    logic [4:0]  trial;
    logic        ge;
    logic [1:0]  hlen;
    logic [7:0]  ch;
    logic        emit;
    logic        ph_end;
    logic        adv;
    t_phase      nph;
    logic signed [8:0] wcalc;
    logic [3:0]  dsel;
    logic [5:0]  rd_idx;

    assign o_job_ready = (r_state == S_IDLE);
    assign m_out.valid = r_ovalid;
    assign m_out.data = '{text_char: r_ochar, last: r_olast};
    assign hlen = {1'b0, r_job.has_sign} + r_job.prefix_len;
    assign trial = {r_rem[3:0], r_quo[63]};
    assign ge = trial >= r_job.base;
    assign wcalc = $signed({3'd0, r_job.width}) - $signed({7'd0, hlen})
                 - $signed({2'd0, r_n});
    assign adv = (r_state == S_EMIT) && (!r_ovalid || m_out.ready);
    assign dsel = r_dout;

    // digit store read address follows the digit counter one step ahead
    always_comb begin
        if (r_state == S_PLAN) rd_idx = r_n[5:0] - 6'd1;
        else if (adv && r_ph == P_DIG) rd_idx = r_cnt[5:0] - 6'd1;
        else rd_idx = r_cnt[5:0];
    end

    always_ff @(posedge i_clk) begin
        r_dout <= r_dg[rd_idx];
    end

    always_comb begin
        ch = 8'h20;
        emit = 1'b1;
        ph_end = 1'b0;
        unique case (r_ph)
            P_LSP: begin
                ch = 8'h20; emit = (r_w > 0); ph_end = (r_w <= 1);
            end
            P_HEAD: begin
                emit = (r_hk < hlen);
                if (r_job.has_sign && r_hk == 2'd0) ch = r_job.sign_char;
                else if ((r_hk == 2'd1 && r_job.has_sign) ||
                         (r_hk == 2'd0 && !r_job.has_sign)) ch = 8'h30;
                else ch = r_job.upper_case ? 8'h58 : 8'h78;
                ph_end = (r_hk + 2'd1 >= hlen);
            end
            P_ZPAD: begin
                ch = 8'h30; emit = (r_w > 0); ph_end = (r_w <= 1);
            end
            P_PREC: begin
                ch = 8'h30; emit = (r_prec > $signed({2'd0, r_n}));
                ph_end = (r_prec <= $signed({2'd0, r_n}) + 9'sd1);
            end
            P_DIG: begin
                ch = digit_char(dsel, r_job.upper_case); ph_end = (r_cnt == 7'd0);
            end
            P_TSP: begin
                ch = 8'h20; emit = (r_w > 0); ph_end = (r_w <= 1);
            end
            default: begin
                emit = 1'b0; ph_end = 1'b1;
            end
        endcase
        unique case (r_ph)
            P_LSP: nph = P_HEAD;
            P_HEAD: nph = r_job.zero_pad ? P_ZPAD : P_PREC;
            P_ZPAD: nph = P_PREC;
            P_PREC: nph = P_DIG;
            // trailing spaces only when some width is left over
            P_DIG: nph = (r_job.left_align && r_w > 0) ? P_TSP : P_DONE;
            default: nph = P_DONE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ovalid <= 1'b0;
            r_tl <= '0;
        end else begin
            if (adv && emit) r_ovalid <= 1'b1;
            else if (m_out.valid && m_out.ready) r_ovalid <= 1'b0;
            unique case (r_state)
                S_IDLE: if (i_job_valid) begin
                    r_job <= i_job;
                    r_quo <= i_job.mag;
                    r_rem <= '0;
                    r_bit <= 7'd0;
                    r_n <= 7'd0;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    // one quotient bit per cycle
                    r_quo <= {r_quo[62:0], ge};
                    if (r_bit == 7'd63) begin
                        r_dg[r_n[5:0]] <= 4'(ge ? trial - r_job.base : trial);
                        r_n <= r_n + 7'd1;
                        r_bit <= 7'd0;
                        r_rem <= '0;
                        if ({r_quo[62:0], ge} == 64'd0 || r_n == 7'd63)
                            r_state <= S_PLAN;
                    end else begin
                        r_bit <= r_bit + 7'd1;
                        r_rem <= ge ? trial - r_job.base : trial;
                    end
                end
                S_PLAN: begin
                    r_w <= wcalc;
                    r_prec <= $signed({3'd0, r_job.precision});
                    r_hk <= 2'd0;
                    r_cnt <= r_n - 7'd1;
                    r_tl <= '0;
                    r_ph <= (r_job.zero_pad || r_job.left_align) ? P_HEAD : P_LSP;
                    r_state <= S_EMIT;
                end
                S_EMIT: if (adv) begin
                    if (emit) begin
                        r_ochar <= ch;
                        r_tl <= r_tl + TW'(1);
                        r_olast <= (ph_end && nph == P_DONE) ||
                                   (r_tl == TW'(MAX_TEXT - 1));
                    end
                    unique case (r_ph)
                        P_LSP, P_TSP: if (emit) r_w <= r_w - 9'sd1;
                        P_ZPAD: if (emit) begin
                            r_w <= r_w - 9'sd1; r_prec <= r_prec - 9'sd1;
                        end
                        P_HEAD: r_hk <= r_hk + 2'd1;
                        P_PREC: if (emit) r_prec <= r_prec - 9'sd1;
                        P_DIG: r_cnt <= r_cnt - 7'd1;
                        default: ;
                    endcase
                    if (ph_end) r_ph <= nph;
                    if ((emit && r_tl == TW'(MAX_TEXT - 1)) || (ph_end && nph == P_DONE))
                        r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tl <= TW'(MAX_TEXT)) else $error("text too long");
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !o_job_ready) else $error("ready while busy");
    a_ndig: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) |-> (r_n != 7'd0)) else $error("no digits");
endmodule

@@ hw/rtl/integer_to_text_formatter_core.sv @@
// top level of the printf style integer to text formatter
// usage:
// - i_req carries one 64-bit number with its format options per item
// - o_chr returns the text one character per item, last set on the final one
// - a front stage classifies the number (base, sign, magnitude, prefix) and
//   pushes it into a two entry job queue, so new numbers are taken while the
//   back stage is still busy
// - the back stage divides the magnitude by the base one quotient bit per cycle,
//   a digit per pass, then emits one character per cycle while o_chr is ready
// - from an idle block, the first character follows the division of all
//   digits and a planning step; phases with nothing to emit (spaces, sign
//   and prefix, padding, precision) may also pass before it
// - the back stage takes the next job from the queue only once it is idle
// - a stalled receiver holds the output register; emission waits, and the
//   front keeps filling the queue until it is full
// - reset empties the queue and returns the back stage to idle
// - text beyond MAX_TEXT characters is dropped, last set on the final one
module integer_to_text_formatter_core #(
    parameter int MAX_TEXT = itf_pkg::MaxTextDefault
) (
    input  logic i_clk,
    input  logic i_rst_n,
    itf_if.sink   i_req,
    itf_if.source o_chr
);
    import itf_pkg::*;
    t_job job;
    logic job_valid;
    logic job_ready;

    // front: classify and queue
    itf_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .s_in(i_req),
        .o_job(job), .o_job_valid(job_valid), .i_job_ready(job_ready)
    );

    // back: digits and characters
    itf_back #(.MAX_TEXT(MAX_TEXT)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_job(job),
        .i_job_valid(job_valid), .o_job_ready(job_ready), .m_out(o_chr)
    );
endmodule
